// ===== rtl/wscf_pkg.sv =====
// ----------------------------------------------------------------------------
// wscf_pkg
// Shared types, constants and helpers of the window sum contrast filter.
// ----------------------------------------------------------------------------
package wscf_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_GAIN   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam int          DIM_W       = 13;
    localparam logic [12:0] WIDTH_RST   = 13'd640;
    localparam logic [12:0] HEIGHT_RST  = 13'd480;
    localparam int          DIM_LIMIT   = 8191;

    // divisor of the contrast term and its rounded-up reciprocal
    localparam logic [63:0] DIVISOR     = 64'(5 * 5 * 255 * 3 * 255);
    localparam int          RECIP_SHIFT = 54;
    localparam logic [63:0] RECIP_FULL  =
        ((64'd1 << RECIP_SHIFT) + DIVISOR - 64'd1) / DIVISOR;
    localparam logic [31:0] RECIP       = RECIP_FULL[31:0];

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       drain;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_out;

    // one queued beat: pixel {b,g,r}, its column and the result it causes
    typedef struct packed {
        logic [23:0] pix;
        logic [12:0] col;
        logic        res;
        logic        inter;
        logic        fend;
    } t_entry;

    // r+g+b of one packed pixel
    function automatic logic [9:0] rgb_sum(input logic [23:0] p);
        rgb_sum = 10'(p[7:0]) + 10'(p[15:8]) + 10'(p[23:16]);
    endfunction

endpackage

// ===== rtl/wscf_front.sv =====
// ----------------------------------------------------------------------------
// wscf_front
// Config registers, raster counters and per-beat classification.
// ----------------------------------------------------------------------------
module wscf_front import wscf_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    output logic        o_push_valid,
    input  logic        i_push_ready,
    output t_entry      o_push_data,
    output logic [8:0]  o_gain
);

    localparam int WCAP = (MAX_WIDTH > DIM_LIMIT) ? DIM_LIMIT : MAX_WIDTH;
    localparam int HCAP = (MAX_HEIGHT > DIM_LIMIT) ? DIM_LIMIT : MAX_HEIGHT;
    localparam int CW   = $clog2(WCAP);
    localparam logic [12:0] WMAX = 13'(WCAP);
    localparam logic [12:0] HMAX = 13'(HCAP);

    logic [8:0]    r_gain;
    logic [12:0]   r_width;
    logic [12:0]   r_height;
    logic [CW-1:0] r_col;
    logic [13:0]   r_row;
    logic [14:0]   r_lead;
    logic [CW-1:0] r_ocol;
    logic [12:0]   r_orow;

    logic [12:0] w_eff;
    logic [12:0] h_eff;
    logic [14:0] w_lim;
    logic        w_in_frame;
    logic        w_skip;
    logic        w_accept;
    logic        w_res;
    logic        w_inter;
    logic        w_fend;

    // effective frame size
    always_comb begin
        w_eff = (r_width == 13'd0) ? 13'd1 : ((r_width > WMAX) ? WMAX : r_width);
        h_eff = (r_height == 13'd0) ? 13'd1 : ((r_height > HMAX) ? HMAX : r_height);
    end

    // classification of the current beat
    always_comb begin
        w_lim      = {1'b0, w_eff, 1'b0} + 15'd2;
        w_in_frame = r_row < {1'b0, h_eff};
        w_skip     = i_data.drain && w_in_frame;
        w_accept   = i_valid && i_push_ready;
        w_res      = (r_lead == w_lim);
        w_inter    = (r_orow >= 13'd2) && ((14'(r_orow) + 14'd2) < {1'b0, h_eff})
                  && (14'(r_ocol) >= 14'd2) && ((14'(r_ocol) + 14'd2) < {1'b0, w_eff});
        w_fend     = (r_orow == (h_eff - 13'd1)) && (13'(r_ocol) == (w_eff - 13'd1));
    end

    assign o_ready      = i_push_ready;
    assign o_cfg_ready  = 1'b1;
    assign o_gain       = r_gain;
    assign o_push_valid = w_accept && !w_skip;

    always_comb begin
        o_push_data.pix   = {i_data.blue_in, i_data.green_in, i_data.red_in};
        o_push_data.col   = 13'(r_col);
        o_push_data.res   = w_res;
        o_push_data.inter = w_inter;
        o_push_data.fend  = w_fend;
    end

    // registers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= 9'd0;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
            r_lead   <= '0;
            r_ocol   <= '0;
            r_orow   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAIN: begin
                    r_gain <= i_cfg_data[8:0];
                end
                CFG_WIDTH: begin
                    r_width <= i_cfg_data;
                    r_col   <= '0;
                    r_row   <= '0;
                    r_lead  <= '0;
                    r_ocol  <= '0;
                    r_orow  <= '0;
                end
                CFG_HEIGHT: begin
                    r_height <= i_cfg_data;
                    r_col    <= '0;
                    r_row    <= '0;
                    r_lead   <= '0;
                    r_ocol   <= '0;
                    r_orow   <= '0;
                end
                default: begin
                end
            endcase
        end else if (w_accept && !w_skip) begin
            if (w_res && w_fend) begin
                // last result of the frame restarts everything
                r_col  <= '0;
                r_row  <= '0;
                r_lead <= '0;
                r_ocol <= '0;
                r_orow <= '0;
            end else begin
                if ((14'(r_col) + 14'd1) >= {1'b0, w_eff}) begin
                    r_col <= '0;
                    r_row <= r_row + 14'd1;
                end else begin
                    r_col <= r_col + CW'(1);
                end
                if (!w_res) begin
                    r_lead <= r_lead + 15'd1;
                end else if ((14'(r_ocol) + 14'd1) >= {1'b0, w_eff}) begin
                    r_ocol <= '0;
                    r_orow <= r_orow + 13'd1;
                end else begin
                    r_ocol <= r_ocol + CW'(1);
                end
            end
        end
    end

endmodule

// ===== rtl/wscf_queue.sv =====
// ----------------------------------------------------------------------------
// wscf_queue
// Four-entry queue between the classifier and the filter datapath.
// ----------------------------------------------------------------------------
module wscf_queue import wscf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_entry i_push_data,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_entry o_pop_data
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready = (r_count != (PW+1)'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/wscf_back.sv =====
// ----------------------------------------------------------------------------
// wscf_back
// Line memory, 5x5 window sum and per-channel contrast arithmetic.
// ----------------------------------------------------------------------------
module wscf_back import wscf_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pop_valid,
    output logic       o_pop_ready,
    input  t_entry     i_pop_data,
    input  logic [8:0] i_gain,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out       o_data
);

    localparam int WCAP = (MAX_WIDTH > DIM_LIMIT) ? DIM_LIMIT : MAX_WIDTH;
    localparam int CW   = $clog2(WCAP);

    typedef struct packed {
        logic        res;
        logic        inter;
        logic        fend;
        logic [23:0] pix;
    } t_tag;

    // saturating add or subtract of the contrast term
    function automatic logic [7:0] shape(input logic [7:0] p, input logic [8:0] q,
                                         input logic neg);
        logic [9:0] s;
        s = 10'(p) + 10'(q);
        if (neg) begin
            shape = (q > {1'b0, p}) ? 8'd0 : (p - q[7:0]);
        end else begin
            shape = (s > 10'd255) ? 8'd255 : s[7:0];
        end
    endfunction

    logic        w_adv;
    logic        w_pop;
    logic        r_out_valid;
    t_out        r_out;

    logic [95:0] r_line [WCAP];
    logic [95:0] r_rd;
    logic        r_fwd;
    logic [95:0] r_fwd_word;
    logic [95:0] w_word;
    logic [95:0] w_wr;
    logic [11:0] w_cs;

    logic        r_s1_v;
    t_entry      r_s1;
    logic        r_s2_v;
    t_tag        r_s2;
    logic [11:0] r_cs [5];
    logic [23:0] r_ctr [2];
    logic        r_s3_v;
    t_tag        r_s3;
    logic [14:0] r_sum;
    logic        r_s4_v;
    t_tag        r_s4;
    logic [22:0] r_at;
    logic        r_s4_neg;
    logic        r_s5_v;
    t_tag        r_s5;
    logic        r_s5_neg;
    logic [30:0] r_x [3];
    logic        r_s6_v;
    t_tag        r_s6;
    logic        r_s6_neg;
    logic [62:0] r_prod [3];

    logic signed [23:0] w_t;
    logic [23:0]        w_tu;
    logic [23:0]        w_abs;

    assign w_adv       = !r_out_valid || i_ready;
    assign w_pop       = i_pop_valid && w_adv;
    assign o_pop_ready = w_adv;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    // line memory: one word per column holds the four rows above
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_rd <= r_line[i_pop_data.col[CW-1:0]];
        end
        if (w_adv && r_s1_v) begin
            r_line[r_s1.col[CW-1:0]] <= w_wr;
        end
    end

    // bypass when the next beat reads the column just written
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_fwd      <= r_s1_v && (r_s1.col == i_pop_data.col);
            r_fwd_word <= w_wr;
        end
    end

    // column of five pixels and its sum
    always_comb begin
        w_word = r_fwd ? r_fwd_word : r_rd;
        w_wr   = {w_word[71:0], r_s1.pix};
        w_cs   = 12'(rgb_sum(r_s1.pix)) + 12'(rgb_sum(w_word[23:0]))
               + 12'(rgb_sum(w_word[47:24])) + 12'(rgb_sum(w_word[71:48]))
               + 12'(rgb_sum(w_word[95:72]));
    end

    // gain times window sum, split into magnitude and sign
    always_comb begin
        w_t   = $signed({{15{i_gain[8]}}, i_gain}) * $signed({9'd0, r_sum});
        w_tu  = w_t;
        w_abs = w_tu[23] ? (~w_tu + 24'd1) : w_tu;
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_s4_v      <= 1'b0;
            r_s5_v      <= 1'b0;
            r_s6_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_v      <= w_pop;
            r_s2_v      <= r_s1_v;
            r_s3_v      <= r_s2_v;
            r_s4_v      <= r_s3_v;
            r_s5_v      <= r_s4_v;
            r_s6_v      <= r_s5_v;
            r_out_valid <= r_s6_v && r_s6.res;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_pop) begin
                r_s1 <= i_pop_data;
            end
            // column sums and center pixels shift once per beat
            if (r_s1_v) begin
                r_cs[0]  <= w_cs;
                r_cs[1]  <= r_cs[0];
                r_cs[2]  <= r_cs[1];
                r_cs[3]  <= r_cs[2];
                r_cs[4]  <= r_cs[3];
                r_ctr[0] <= w_word[47:24];
                r_ctr[1] <= r_ctr[0];
                r_s2.res   <= r_s1.res;
                r_s2.inter <= r_s1.inter;
                r_s2.fend  <= r_s1.fend;
                r_s2.pix   <= r_ctr[1];
            end
            // window sum
            r_sum     <= 15'(r_cs[0]) + 15'(r_cs[1]) + 15'(r_cs[2])
                       + 15'(r_cs[3]) + 15'(r_cs[4]);
            r_s3      <= r_s2;
            // contrast term
            r_at      <= w_abs[22:0];
            r_s4_neg  <= w_tu[23];
            r_s4      <= r_s3;
            // per channel product
            r_x[0]    <= 31'(r_s4.pix[7:0]) * 31'(r_at);
            r_x[1]    <= 31'(r_s4.pix[15:8]) * 31'(r_at);
            r_x[2]    <= 31'(r_s4.pix[23:16]) * 31'(r_at);
            r_s5_neg  <= r_s4_neg;
            r_s5      <= r_s4;
            // division by reciprocal multiplication
            r_prod[0] <= 63'(r_x[0]) * 63'(RECIP);
            r_prod[1] <= 63'(r_x[1]) * 63'(RECIP);
            r_prod[2] <= 63'(r_x[2]) * 63'(RECIP);
            r_s6_neg  <= r_s5_neg;
            r_s6      <= r_s5;
            // output register
            r_out.frame_end <= r_s6.fend;
            if (r_s6.inter) begin
                r_out.red_out   <= shape(r_s6.pix[7:0],   r_prod[0][62:54], r_s6_neg);
                r_out.green_out <= shape(r_s6.pix[15:8],  r_prod[1][62:54], r_s6_neg);
                r_out.blue_out  <= shape(r_s6.pix[23:16], r_prod[2][62:54], r_s6_neg);
            end else begin
                r_out.red_out   <= r_s6.pix[7:0];
                r_out.green_out <= r_s6.pix[15:8];
                r_out.blue_out  <= r_s6.pix[23:16];
            end
        end
    end

endmodule

// ===== rtl/window_sum_contrast_filter.sv =====
// ----------------------------------------------------------------------------
// window_sum_contrast_filter
// 5x5 local dynamic range filter over an RGB raster stream.
// ----------------------------------------------------------------------------
// Pixels enter on i_valid/o_ready with i_data, results leave on
// o_valid/i_ready with o_data. The config channel writes gain, image_width
// and image_height; writing a size restarts the frame. Config is taken every
// cycle and should only be written while the block is idle.
// Each beat that is not an ignored drain produces at most one result: the
// pixel 2*width+2 beats earlier in raster order. After the last pixel of a
// frame the host sends drain beats to flush the remaining results; the
// result with frame_end set ends the frame.
// Throughput is one beat per cycle while the queue has room. On its way out a
// result passes the line memory read, the window sum, three multiply stages
// (gain, channel, reciprocal) and the output register.
// A four-entry queue separates the classifier from the datapath; when the
// receiver stalls the datapath holds and o_ready drops once the queue fills.
// Reset clears counters and pipeline valids and loads default config; the
// line memory is not cleared.
// ----------------------------------------------------------------------------
module window_sum_contrast_filter import wscf_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    logic       w_push_valid;
    logic       w_push_ready;
    t_entry     w_push_data;
    logic       w_pop_valid;
    logic       w_pop_ready;
    t_entry     w_pop_data;
    logic [8:0] w_gain;

    // classifier
    wscf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data),
        .o_gain       (w_gain)
    );

    // decoupling queue
    wscf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    // filter datapath
    wscf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .i_gain      (w_gain),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// ===== sim/wscf_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wscf_checker
// Watches the pixel, result and config channels of the window sum contrast
// filter, keeps its own copy of the frame history and settings, works out
// the result of every accepted pixel beat and compares it with the result
// beats in order. Mismatches and stray results raise the failure count.
// ----------------------------------------------------------------------------
module wscf_checker import wscf_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out        i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int unsigned HIST_DEPTH   = 4 * MAX_WIDTH + 5;
    localparam longint      CONTRAST_DIV = 64'd4876875;

    logic [23:0] pix_hist [HIST_DEPTH];
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned out_idx;
    logic [8:0]  gain_r;
    logic [12:0] width_r;
    logic [12:0] height_r;
    t_out        pixel_q [$];
    int          fail_cnt;

    assign o_fail_count = fail_cnt;

    function automatic int unsigned clamp_dim(input logic [12:0] v, input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // p + p*t/div truncated toward zero, limited to a byte
    function automatic logic [7:0] shape_chan(input logic [7:0] p, input longint t);
        longint v;
        v = (longint'(p) * t) / CONTRAST_DIV + longint'(p);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // advance the frame by one pixel beat, returns 1 when a result is due
    function automatic bit filter_beat(input t_in d, output t_out r);
        int unsigned w, h, n, k, i, j, base, sum, r0, c0;
        logic [23:0] px, q;
        longint t;
        r = '0;
        w = clamp_dim(width_r, MAX_WIDTH);
        h = clamp_dim(height_r, MAX_HEIGHT);
        n = row_cnt * w + col_cnt;
        if (row_cnt < h) begin
            if (d.drain) return 0;
            pix_hist[n % HIST_DEPTH] = {d.blue_in, d.green_in, d.red_in};
        end
        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (n < 2 * w + 2) return 0;

        k  = out_idx;
        i  = k / w;
        j  = k % w;
        px = pix_hist[k % HIST_DEPTH];
        if (i >= 2 && i + 2 < h && j >= 2 && j + 2 < w) begin
            sum  = 0;
            base = k - 2 * w - 2;
            for (r0 = 0; r0 < 5; r0++) begin
                for (c0 = 0; c0 < 5; c0++) begin
                    q = pix_hist[(base + r0 * w + c0) % HIST_DEPTH];
                    sum += q[7:0] + q[15:8] + q[23:16];
                end
            end
            t = longint'($signed(gain_r)) * longint'(sum);
            r.red_out   = shape_chan(px[7:0], t);
            r.green_out = shape_chan(px[15:8], t);
            r.blue_out  = shape_chan(px[23:16], t);
        end else begin
            r.red_out   = px[7:0];
            r.green_out = px[15:8];
            r.blue_out  = px[23:16];
        end
        r.frame_end = (k + 1 >= w * h);
        if (r.frame_end) begin
            col_cnt = 0;
            row_cnt = 0;
            out_idx = 0;
        end else begin
            out_idx = k + 1;
        end
        return 1;
    endfunction

    // follow the channels and compare results in order
    always @(posedge i_clk) begin
        t_out res;
        t_out exp_pix;
        if (!i_rst_n) begin
            col_cnt  = 0;
            row_cnt  = 0;
            out_idx  = 0;
            gain_r   = '0;
            width_r  = WIDTH_RST;
            height_r = HEIGHT_RST;
            pixel_q.delete();
            fail_cnt = 0;
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GAIN: begin
                        gain_r = i_cfg_data[8:0];
                    end
                    CFG_WIDTH: begin
                        width_r = i_cfg_data;
                        col_cnt = 0;
                        row_cnt = 0;
                        out_idx = 0;
                    end
                    CFG_HEIGHT: begin
                        height_r = i_cfg_data;
                        col_cnt  = 0;
                        row_cnt  = 0;
                        out_idx  = 0;
                    end
                    default: ;
                endcase
            end
            // pixel beats
            if (i_in_valid && i_in_ready) begin
                if (filter_beat(i_in_data, res)) pixel_q.push_back(res);
            end
            // result beats
            if (i_out_valid && i_out_ready) begin
                if (pixel_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", i_out_data);
                    fail_cnt = fail_cnt + 1;
                end else begin
                    exp_pix = pixel_q.pop_front();
                    if (i_out_data.red_out !== exp_pix.red_out) begin
                        $error("red_out expected %0d actual %0d",
                               exp_pix.red_out, i_out_data.red_out);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (i_out_data.green_out !== exp_pix.green_out) begin
                        $error("green_out expected %0d actual %0d",
                               exp_pix.green_out, i_out_data.green_out);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (i_out_data.blue_out !== exp_pix.blue_out) begin
                        $error("blue_out expected %0d actual %0d",
                               exp_pix.blue_out, i_out_data.blue_out);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (i_out_data.frame_end !== exp_pix.frame_end) begin
                        $error("frame_end expected %0d actual %0d",
                               exp_pix.frame_end, i_out_data.frame_end);
                        fail_cnt = fail_cnt + 1;
                    end
                end
            end
        end
        o_pending <= pixel_q.size();
    end

endmodule

// ===== sim/window_sum_contrast_filter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_sum_contrast_filter_tb
// Drives frames of many sizes, gains and contents through the filter with
// random gaps and back-pressure; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module window_sum_contrast_filter_tb;
    import wscf_pkg::*;

    localparam int MAX_DIM     = 4096;
    localparam int IDLE_CYCLES = 30;
    localparam int STALL_LIMIT = 5000;
    localparam int ITEM_GOAL   = 1750;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_data;
    logic        o_valid;
    logic        i_ready;
    t_out        o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [12:0] i_cfg_data;

    int fail_count;
    int pending;
    int beats_sent;
    int quiet_cycles = 0;
    bit burst;
    int cur_w;
    int cur_h;

    window_sum_contrast_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    wscf_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side back-pressure
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    function automatic int eff_dim(input int v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    // fill 0 random, 1 all max, 2 all zero, 3 random extremes
    function automatic t_in make_pixel(input int fill);
        t_in d;
        d.drain = 1'b0;
        case (fill)
            1: {d.red_in, d.green_in, d.blue_in} = '1;
            2: {d.red_in, d.green_in, d.blue_in} = '0;
            3: begin
                d.red_in   = $urandom_range(0, 1) ? 8'hff : 8'h00;
                d.green_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
                d.blue_in  = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
            default: {d.red_in, d.green_in, d.blue_in} = 24'($urandom);
        endcase
        return d;
    endfunction

    // one pixel beat, entered and left at a falling edge
    task automatic send_beat(input t_in d);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic send_drain();
        t_in d;
        d       = make_pixel(0);
        d.drain = 1'b1;
        send_beat(d);
    endtask

    // register write once all results are out and the pipeline is empty
    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (IDLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH) cur_w = eff_dim(val);
        if (idx == CFG_HEIGHT) cur_h = eff_dim(val);
    endtask

    task automatic write_gain(input logic [8:0] g);
        write_reg(CFG_GAIN, {4'($urandom), g});
    endtask

    // full frame: pixels with stray drains, then the flush beats
    task automatic run_frame(input int fill, input int noise_pct);
        int n;
        burst = ($urandom_range(0, 3) == 0);
        for (n = 0; n < cur_w * cur_h; n++) begin
            if ($urandom_range(0, 99) < noise_pct) send_drain();
            send_beat(make_pixel(fill));
            beats_sent++;
        end
        // a pixel during the flush counts as a drain
        for (n = 0; n < 2 * cur_w + 2; n++) begin
            if ($urandom_range(0, 3) == 0) send_beat(make_pixel(0));
            else send_drain();
            beats_sent++;
        end
        if ($urandom_range(0, 3) == 0) send_drain();
    endtask

    // start of a frame that a size write will cut off
    task automatic run_partial(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            send_beat(make_pixel(3));
            beats_sent++;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_GAIN;
        i_cfg_data   = '0;
        beats_sent   = 0;
        burst        = 1'b0;
        cur_w        = 640;
        cur_h        = 480;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // strongest positive and negative gain on a white frame, then a black frame
        write_reg(CFG_WIDTH, 13'd5);
        write_reg(CFG_HEIGHT, 13'd5);
        write_gain(9'd255);
        run_frame(1, 10);
        write_gain(9'h100);
        run_frame(1, 10);
        run_frame(2, 0);

        // zero sizes act as one, unknown register index does nothing
        write_reg(CFG_WIDTH, 13'd0);
        write_reg(CFG_HEIGHT, 13'd0);
        write_reg(2'd3, 13'($urandom));
        run_frame(0, 20);

        // oversized dims, frames abandoned by a size write
        write_reg(CFG_WIDTH, 13'h1fff);
        write_reg(CFG_HEIGHT, 13'd2);
        run_partial(12);
        write_reg(CFG_WIDTH, 13'd1);
        write_reg(CFG_HEIGHT, 13'h1fff);
        run_partial(15);
        write_reg(CFG_WIDTH, 13'd4096);
        write_reg(CFG_HEIGHT, 13'd4096);
        run_partial(5);

        // back to a small frame before the random part
        write_reg(CFG_WIDTH, 13'd6);
        write_reg(CFG_HEIGHT, 13'd5);

        // random frames, mostly big enough to have an interior
        while (beats_sent < ITEM_GOAL) begin
            if ($urandom_range(0, 4) != 0) write_gain(9'($urandom));
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_WIDTH, ($urandom_range(0, 4) == 0) ?
                          13'($urandom_range(0, 4)) : 13'($urandom_range(5, 10)));
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_HEIGHT, ($urandom_range(0, 4) == 0) ?
                          13'($urandom_range(0, 4)) : 13'($urandom_range(5, 9)));
            run_frame(($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0, 8);
        end

        // let the last results come out
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (IDLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wscf_pkg.sv
rtl/wscf_front.sv
rtl/wscf_queue.sv
rtl/wscf_back.sv
rtl/window_sum_contrast_filter.sv
sim/wscf_checker.sv
sim/window_sum_contrast_filter_tb.sv
